[rtl/pcb_pkg.sv]
// ----------------------------------------------------------------------------
// pcb_pkg: shared types and constants for the preload CAN command bridge
// Command codes, flag bits, configuration record, item and result records,
// and the small helpers that build transmit frames and clamp positions.
// ----------------------------------------------------------------------------
`default_nettype none

package pcb_pkg;

  // Event kinds carried by the mode field
  typedef enum logic [1:0] {
    MODE_HOST = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TICK = 2'd2,
    MODE_ACK  = 2'd3
  } mode_t;

  // Which frame the last tick put on the bus
  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_PENDING    = 2'd1,
    OUT_POLL       = 2'd2,
    OUT_SUPERSEDED = 2'd3
  } outstanding_t;

  // Host command codes
  localparam logic [7:0] CMD_SET_TARGET        = 8'h01;
  localparam logic [7:0] CMD_LOAD_PRESET       = 8'h02;
  localparam logic [7:0] CMD_SAVE_CURRENT      = 8'h03;
  localparam logic [7:0] CMD_STOP              = 8'h04;
  localparam logic [7:0] CMD_CLEAR_ALARMS      = 8'h05;
  localparam logic [7:0] CMD_MOVE_RELATIVE     = 8'h06;
  localparam logic [7:0] CMD_REQUEST_STATUS    = 8'h10;
  localparam logic [7:0] CMD_SET_POSITION_REF  = 8'h11;
  localparam logic [7:0] CMD_START_CALIBRATION = 8'h12;

  // First byte of a status frame that carries a preset report
  localparam logic [7:0] PRESET_REPORT_KIND = 8'hF0;

  // Status flag bit positions
  localparam int FL_STATUS_SEEN = 0;
  localparam int FL_ALARM_SEEN  = 1;
  localparam int FL_TIMEOUT     = 2;
  localparam int FL_ACTIVE      = 3;
  localparam int FL_TX_TRIED    = 4;
  localparam int FL_TX_OK       = 5;
  localparam int FL_TX_FAILED   = 6;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_POSITION    = 3'd0;
  localparam logic [2:0] CFG_TIMEOUT_MS      = 3'd1;
  localparam logic [2:0] CFG_POLL_PERIOD_MS  = 3'd2;
  localparam logic [2:0] CFG_STATUS_FRAME_ID = 3'd3;
  localparam logic [2:0] CFG_ALARM_FRAME_ID  = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  RST_MAX_POSITION    = 8'd100;
  localparam logic [15:0] RST_TIMEOUT_MS      = 16'd1000;
  localparam logic [15:0] RST_POLL_PERIOD_MS  = 16'd100;
  localparam logic [10:0] RST_STATUS_FRAME_ID = 11'h721;
  localparam logic [10:0] RST_ALARM_FRAME_ID  = 11'h722;

  localparam logic [15:0] AGE_NEVER = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  max_position;
    logic [15:0] timeout_ms;
    logic [15:0] poll_period_ms;
    logic [10:0] status_frame_id;
    logic [10:0] alarm_frame_id;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  command;
    logic [15:0] value;
    logic [7:0]  slot;
    logic [10:0] frame_id;
    logic        frame_extended;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        tx_ok;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [1:0]  tx_len;
    logic [23:0] tx_payload;
    logic [7:0]  target;
    logic [7:0]  position;
    logic [7:0]  controller_target;
    logic [7:0]  active_slot;
    logic [7:0]  controller_state;
    logic [15:0] alarms;
    logic [7:0]  status_flags;
    logic [15:0] motor_current;
  } result_t;

  // Limit a reported value to the configured maximum
  function automatic logic [7:0] clamp_max(input logic [15:0] v, input logic [7:0] max_pos);
    clamp_max = (v > {8'd0, max_pos}) ? max_pos : v[7:0];
  endfunction

  // Frame length for a command code
  function automatic logic [1:0] frame_len(input logic [7:0] code);
    case (code)
      CMD_SET_TARGET, CMD_SET_POSITION_REF, CMD_MOVE_RELATIVE: frame_len = 2'd3;
      CMD_LOAD_PRESET, CMD_SAVE_CURRENT:                       frame_len = 2'd2;
      default:                                                 frame_len = 2'd1;
    endcase
  endfunction

  // Frame bytes for a command code: code, then value or slot
  function automatic logic [23:0] frame_bytes(input logic [7:0] code,
                                              input logic [15:0] value,
                                              input logic [7:0] slot);
    case (code)
      CMD_SET_TARGET, CMD_SET_POSITION_REF, CMD_MOVE_RELATIVE:
        frame_bytes = {value, code};
      CMD_LOAD_PRESET, CMD_SAVE_CURRENT:
        frame_bytes = {8'd0, slot, code};
      default:
        frame_bytes = {16'd0, code};
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/pcb_cfg.sv]
// ----------------------------------------------------------------------------
// pcb_cfg: configuration registers
// Holds the five bridge settings, loaded from the write port by index.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata,
  output pcb_pkg::cfg_t     cfg
);
  import pcb_pkg::*;

  cfg_t cfg_r;

  // Load the addressed register; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_position    <= RST_MAX_POSITION;
      cfg_r.timeout_ms      <= RST_TIMEOUT_MS;
      cfg_r.poll_period_ms  <= RST_POLL_PERIOD_MS;
      cfg_r.status_frame_id <= RST_STATUS_FRAME_ID;
      cfg_r.alarm_frame_id  <= RST_ALARM_FRAME_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_POSITION:    cfg_r.max_position    <= cfg_wdata[7:0];
        CFG_TIMEOUT_MS:      cfg_r.timeout_ms      <= cfg_wdata;
        CFG_POLL_PERIOD_MS:  cfg_r.poll_period_ms  <= cfg_wdata;
        CFG_STATUS_FRAME_ID: cfg_r.status_frame_id <= cfg_wdata[10:0];
        CFG_ALARM_FRAME_ID:  cfg_r.alarm_frame_id  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/pcb_in_reg.sv]
// ----------------------------------------------------------------------------
// pcb_in_reg: input register
// Captures one event per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pcb_pkg::item_t in_item,
  input  wire logic           take,
  output logic                item_vld,
  output pcb_pkg::item_t      item
);
  import pcb_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // Room when empty or when the held event leaves this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

[rtl/pcb_core.sv]
// ----------------------------------------------------------------------------
// pcb_core: bridge state and event decode
// Applies one event per cycle, when fire is set, to the bridge state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_core #(
  parameter int PRESET_SLOTS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pcb_pkg::cfg_t  cfg,
  input  wire pcb_pkg::item_t item,
  input  wire logic           fire,
  output pcb_pkg::result_t    res
);
  import pcb_pkg::*;

  localparam int         SLOT_W     = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
  localparam logic [7:0] SLOT_LIMIT = 8'(PRESET_SLOTS);

  // State registers
  logic [7:0]  target_r, target_nxt;
  logic [7:0]  position_r, position_nxt;
  logic [7:0]  ctgt_r, ctgt_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [7:0]  cstate_r, cstate_nxt;
  logic [15:0] alarm_r, alarm_nxt;
  logic [15:0] current_r, current_nxt;
  logic [15:0] age_r, age_nxt;
  logic [6:0]  flag_r, flag_nxt;
  logic [PRESET_SLOTS-1:0] seen_r, seen_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [7:0]  pend_code_r, pend_code_nxt;
  logic [15:0] pend_value_r, pend_value_nxt;
  logic [7:0]  pend_slot_r, pend_slot_nxt;
  outstanding_t outst_r, outst_nxt;
  logic [15:0] poll_r, poll_nxt;

  logic [7:0]  preset_r [PRESET_SLOTS];
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_idx;
  logic [7:0]        tbl_wdata;

  // Decode helpers
  logic              ok;
  logic              tx_v;
  logic [7:0]        tx_code;
  logic [15:0]       tx_value;
  logic [7:0]        tx_slot;
  logic signed [16:0] delta;
  logic signed [16:0] lim;
  logic signed [16:0] nt;
  logic              cmd_slot_ok;
  logic [SLOT_W-1:0] cmd_idx;
  logic [7:0]        rx_b [8];
  logic              rx_ok;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rx_b[i] = item.frame_data[8*i +: 8];
    end
  end

  assign delta       = {item.value[15], item.value};
  assign lim         = {9'd0, cfg.max_position};
  assign nt          = $signed({9'd0, ctgt_r}) + delta;
  assign cmd_slot_ok = item.slot < SLOT_LIMIT;
  assign cmd_idx     = item.slot[SLOT_W-1:0];
  assign rx_ok       = !item.frame_extended && item.frame_len[3];

  // Next state for one event
  always_comb begin
    target_nxt     = target_r;
    position_nxt   = position_r;
    ctgt_nxt       = ctgt_r;
    slot_nxt       = slot_r;
    cstate_nxt     = cstate_r;
    alarm_nxt      = alarm_r;
    current_nxt    = current_r;
    age_nxt        = age_r;
    flag_nxt       = flag_r;
    seen_nxt       = seen_r;
    pend_vld_nxt   = pend_vld_r;
    pend_code_nxt  = pend_code_r;
    pend_value_nxt = pend_value_r;
    pend_slot_nxt  = pend_slot_r;
    outst_nxt      = outst_r;
    poll_nxt       = poll_r;
    tbl_we         = 1'b0;
    tbl_idx        = cmd_idx;
    tbl_wdata      = position_r;
    ok             = 1'b0;
    tx_v           = 1'b0;
    tx_code        = pend_code_r;
    tx_value       = pend_value_r;
    tx_slot        = pend_slot_r;

    case (mode_t'(item.mode))
      MODE_HOST: begin
        // Range-check the command and apply its local effect
        case (item.command)
          CMD_SET_TARGET: begin
            if (item.value <= {8'd0, cfg.max_position}) begin
              ok         = 1'b1;
              target_nxt = item.value[7:0];
            end
          end
          CMD_LOAD_PRESET: begin
            if (cmd_slot_ok) begin
              ok       = 1'b1;
              slot_nxt = item.slot;
              if (seen_r[cmd_idx]) begin
                target_nxt = preset_r[cmd_idx];
              end
            end
          end
          CMD_SAVE_CURRENT: begin
            if (cmd_slot_ok) begin
              ok                = 1'b1;
              slot_nxt          = item.slot;
              tbl_we            = 1'b1;
              seen_nxt[cmd_idx] = 1'b1;
            end
          end
          CMD_MOVE_RELATIVE: begin
            if (!(delta > lim) && !(delta < -lim)) begin
              ok = 1'b1;
              if (nt < 0) begin
                target_nxt = 8'd0;
              end else if (nt > lim) begin
                target_nxt = cfg.max_position;
              end else begin
                target_nxt = nt[7:0];
              end
            end
          end
          CMD_STOP, CMD_CLEAR_ALARMS, CMD_REQUEST_STATUS, CMD_START_CALIBRATION: begin
            ok = 1'b1;
          end
          CMD_SET_POSITION_REF: begin
            ok = item.value <= {8'd0, cfg.max_position};
          end
          default: ok = 1'b0;
        endcase
        // Hold a valid command as the pending frame
        if (ok) begin
          pend_vld_nxt   = 1'b1;
          pend_code_nxt  = item.command;
          pend_value_nxt = item.value;
          pend_slot_nxt  = item.slot;
          if (outst_r == OUT_PENDING) begin
            outst_nxt = OUT_SUPERSEDED;
          end
        end
      end

      MODE_RX: begin
        // Decode status, preset report or alarm frames
        if (rx_ok && item.frame_id == cfg.status_frame_id) begin
          ok = 1'b1;
          if (rx_b[0] == PRESET_REPORT_KIND) begin
            if (rx_b[1] < SLOT_LIMIT) begin
              tbl_we                        = 1'b1;
              tbl_idx                       = rx_b[1][SLOT_W-1:0];
              tbl_wdata                     = clamp_max({8'd0, rx_b[2]}, cfg.max_position);
              seen_nxt[rx_b[1][SLOT_W-1:0]] = 1'b1;
            end
            if (rx_b[3] < SLOT_LIMIT) begin
              slot_nxt = rx_b[3];
            end
            position_nxt = clamp_max({8'd0, rx_b[4]}, cfg.max_position);
            ctgt_nxt     = clamp_max({8'd0, rx_b[5]}, cfg.max_position);
          end else begin
            position_nxt = clamp_max({rx_b[1], rx_b[0]}, cfg.max_position);
            ctgt_nxt     = clamp_max({rx_b[3], rx_b[2]}, cfg.max_position);
            slot_nxt     = rx_b[4];
            cstate_nxt   = rx_b[5];
          end
          alarm_nxt                = {rx_b[7], rx_b[6]};
          flag_nxt[FL_STATUS_SEEN] = 1'b1;
          age_nxt                  = 16'd0;
        end else if (rx_ok && item.frame_id == cfg.alarm_frame_id) begin
          ok                      = 1'b1;
          alarm_nxt               = {rx_b[1], rx_b[0]};
          position_nxt            = clamp_max({rx_b[3], rx_b[2]}, cfg.max_position);
          ctgt_nxt                = clamp_max({rx_b[5], rx_b[4]}, cfg.max_position);
          current_nxt             = {rx_b[7], rx_b[6]};
          flag_nxt[FL_ALARM_SEEN] = 1'b1;
          age_nxt                 = 16'd0;
        end
      end

      MODE_TICK: begin
        // Advance counters; send the pending frame, else a due poll
        flag_nxt[FL_ACTIVE] = 1'b1;
        if (age_r != AGE_NEVER) begin
          age_nxt = age_r + 16'd1;
        end
        if (poll_r != 16'hFFFF) begin
          poll_nxt = poll_r + 16'd1;
        end
        if (pend_vld_r) begin
          tx_v      = 1'b1;
          outst_nxt = OUT_PENDING;
        end else if (poll_nxt >= cfg.poll_period_ms) begin
          tx_v      = 1'b1;
          tx_code   = CMD_REQUEST_STATUS;
          tx_value  = 16'd0;
          tx_slot   = 8'd0;
          outst_nxt = OUT_POLL;
          poll_nxt  = 16'd0;
        end
        if (tx_v) begin
          flag_nxt[FL_TX_TRIED] = 1'b1;
        end
      end

      MODE_ACK: begin
        // Close the outstanding frame; drop pending only on its own success
        if (outst_r != OUT_NONE) begin
          flag_nxt[FL_TX_OK]     = item.tx_ok;
          flag_nxt[FL_TX_FAILED] = !item.tx_ok;
          if (item.tx_ok && outst_r == OUT_PENDING) begin
            pend_vld_nxt = 1'b0;
          end
          outst_nxt = OUT_NONE;
        end
      end

      default: ;
    endcase

    flag_nxt[FL_TIMEOUT] = age_nxt >= cfg.timeout_ms;
  end

  // Result of this event, taken from the updated state
  always_comb begin
    res.accepted          = ok;
    res.tx_valid          = tx_v;
    res.tx_len            = tx_v ? frame_len(tx_code) : 2'd0;
    res.tx_payload        = tx_v ? frame_bytes(tx_code, tx_value, tx_slot) : 24'd0;
    res.target            = target_nxt;
    res.position          = position_nxt;
    res.controller_target = ctgt_nxt;
    res.active_slot       = slot_nxt;
    res.controller_state  = cstate_nxt;
    res.alarms            = alarm_nxt;
    res.status_flags      = {1'b0, flag_nxt};
    res.motor_current     = current_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      position_r   <= '0;
      ctgt_r       <= '0;
      slot_r       <= '0;
      cstate_r     <= '0;
      alarm_r      <= '0;
      current_r    <= '0;
      age_r        <= AGE_NEVER;
      flag_r       <= '0;
      seen_r       <= '0;
      pend_vld_r   <= 1'b0;
      pend_code_r  <= '0;
      pend_value_r <= '0;
      pend_slot_r  <= '0;
      outst_r      <= OUT_NONE;
      poll_r       <= '0;
    end else if (fire) begin
      target_r     <= target_nxt;
      position_r   <= position_nxt;
      ctgt_r       <= ctgt_nxt;
      slot_r       <= slot_nxt;
      cstate_r     <= cstate_nxt;
      alarm_r      <= alarm_nxt;
      current_r    <= current_nxt;
      age_r        <= age_nxt;
      flag_r       <= flag_nxt;
      seen_r       <= seen_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_code_r  <= pend_code_nxt;
      pend_value_r <= pend_value_nxt;
      pend_slot_r  <= pend_slot_nxt;
      outst_r      <= outst_nxt;
      poll_r       <= poll_nxt;
    end
  end

  // Preset table: entries are read only once their seen bit is set
  always_ff @(posedge clk) begin
    if (fire && tbl_we) begin
      preset_r[tbl_idx] <= tbl_wdata;
    end
  end

`ifndef ASSERT_OFF
  // A frame sent from the pending slot keeps that slot loaded until acked
  a_outst_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (outst_r == OUT_PENDING || outst_r == OUT_SUPERSEDED) |-> pend_vld_r)
    else $error("outstanding pending frame without pending command");

  // A successful ack of the pending frame empties the pending slot
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode == MODE_ACK && item.tx_ok && outst_r == OUT_PENDING)
      |=> (!pend_vld_r && outst_r == OUT_NONE))
    else $error("pending command survived its acknowledge");

  // A tick always leaves the bridge marked active
  a_tick_active: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode == MODE_TICK) |=> flag_r[FL_ACTIVE])
    else $error("tick did not mark the bridge active");
`endif

endmodule

`default_nettype wire

[rtl/preload_can_command_bridge.sv]
// ----------------------------------------------------------------------------
// preload_can_command_bridge: host to CAN actuator command bridge
// Takes one event per transfer (host command, received frame, millisecond
// tick or transmit acknowledge) and returns one result for each. A new event
// is taken every clock unless the decode stage stalls. An event is held in
// the input register after its transfer, decoded against the bridge state
// once the result register has room, and its result is loaded into the
// result register in that same cycle and held there until taken.
// Throughput is set by the single decode stage, which stalls only while the
// result register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module preload_can_command_bridge #(
  parameter int PRESET_SLOTS = 5
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata,
  // Event input
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_mode,
  input  wire logic [7:0]   in_command,
  input  wire logic [15:0]  in_value,
  input  wire logic [7:0]   in_slot,
  input  wire logic [10:0]  in_frame_id,
  input  wire logic         in_frame_extended,
  input  wire logic [3:0]   in_frame_len,
  input  wire logic [63:0]  in_frame_data,
  input  wire logic         in_tx_ok,
  // Result output
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_accepted,
  output logic              out_tx_valid,
  output logic [1:0]        out_tx_len,
  output logic [23:0]       out_tx_payload,
  output logic [7:0]        out_target,
  output logic [7:0]        out_position,
  output logic [7:0]        out_controller_target,
  output logic [7:0]        out_active_slot,
  output logic [7:0]        out_controller_state,
  output logic [15:0]       out_alarms,
  output logic [7:0]        out_status_flags,
  output logic [15:0]       out_motor_current
);
  import pcb_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    fire;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    out_vld_nxt;

  assign in_item = '{mode: in_mode, command: in_command, value: in_value, slot: in_slot,
                     frame_id: in_frame_id, frame_extended: in_frame_extended,
                     frame_len: in_frame_len, frame_data: in_frame_data,
                     tx_ok: in_tx_ok};

  pcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (fire),
    .item_vld (item_vld),
    .item     (item)
  );

  // Decode when an event is held and the result register has room
  assign fire = item_vld && (!out_vld_r || out_ready);

  pcb_core #(
    .PRESET_SLOTS (PRESET_SLOTS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg),
    .item (item),
    .fire (fire),
    .res  (res)
  );

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_accepted          = res_r.accepted;
  assign out_tx_valid          = res_r.tx_valid;
  assign out_tx_len            = res_r.tx_len;
  assign out_tx_payload        = res_r.tx_payload;
  assign out_target            = res_r.target;
  assign out_position          = res_r.position;
  assign out_controller_target = res_r.controller_target;
  assign out_active_slot       = res_r.active_slot;
  assign out_controller_state  = res_r.controller_state;
  assign out_alarms            = res_r.alarms;
  assign out_status_flags      = res_r.status_flags;
  assign out_motor_current     = res_r.motor_current;

`ifndef ASSERT_OFF
  // Accepted commands and frames never send a frame in the same result
  a_acc_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> !out_tx_valid)
    else $error("accepted event also emitted a frame");

  // A result without a frame carries an empty frame field
  a_no_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tx_valid) |-> (out_tx_len == 2'd0 && out_tx_payload == 24'd0))
    else $error("frame bytes present without a frame");

  // Any emitted frame shows up in the tried flag
  a_tx_tried: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_valid) |-> (out_status_flags[FL_TX_TRIED] && out_tx_len != 2'd0))
    else $error("emitted frame without tried flag or length");
`endif

endmodule

`default_nettype wire
